// ===== hdl/mpid_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the multichannel PID controller.
// No dependencies; used by mpid_mul and multichannel_pid_controller_unit.
package mpid_pkg;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [15:0] TIME_STEP_RST     = 16'd655;
  localparam logic [15:0] INV_TIME_STEP_RST = 16'd100;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

// ===== hdl/mpid_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Depends on mpid_pkg.
module mpid_mul (
  input  logic                              clk,
  input  mpid_pkg::mul_req_t                req,
  output logic signed [mpid_pkg::MUL_P_W-1:0] prod_r
);
  import mpid_pkg::*;

  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(req.a) * MUL_P_W'(req.b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== hdl/multichannel_pid_controller_unit.sv =====
`timescale 1ns / 1ps
// Multichannel discrete PID controller, top level.
// Depends on mpid_pkg and mpid_mul.
//
// A gain-load request (tuser = 0) stores Q8.8 kp, ki, kd for a channel and does not hold off
// the next request. A step request (tuser = 1) runs through S_MI, S_AI, S_KP, S_KI, S_KDL,
// S_KDH and S_FIN to a loaded result in S_OUT before the next request is accepted: one
// shared 33x18 signed multiplier runs six products in turn (error*time_step,
// error difference*inverse_time_step, kp*error, ki*integrator and kd*derivative in two
// halves) while an accumulator sums the terms. The input is not ready during that
// sequence; a finished result waits in the output register and does not hold off the
// next request, but a step that finishes while the previous result is still waiting
// stalls there, input not ready, until the output register frees up.
// Requests naming a channel at or above CHANNELS are dropped.
// Registers: time_step at 0x0, inverse_time_step at 0x4.
module multichannel_pid_controller_unit #(
  parameter int CHANNELS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [1:0] channel, [17:2] desired, [33:18] measured, [49:34] prop_gain,
  // [65:50] integ_gain, [81:66] deriv_gain, [87:82] zero
  input  logic [mpid_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] operation
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [1:0] result_channel, [33:2] drive, [39:34] zero
  output logic [mpid_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] saturated
  output logic                                 out_tuser,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [2:0]                           cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import mpid_pkg::*;

  localparam int DEPTH = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MI, S_AI, S_KP, S_KI, S_KDL, S_KDH, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] ts_r;
  logic [15:0] its_r;

  logic signed [31:0] integ_mem_r [DEPTH];
  logic signed [16:0] prev_mem_r  [DEPTH];
  logic        [47:0] gain_mem_r  [DEPTH];

  logic [1:0]         ch_r;
  logic signed [16:0] err_r;
  logic signed [31:0] integ_r;
  logic signed [34:0] deriv_r;
  logic signed [51:0] acc_r;
  logic               hit_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic               out_sat_r;

  logic [1:0]         in_ch;
  logic signed [15:0] in_des, in_meas;
  logic               ch_ok;
  logic [IDX_W-1:0]   idx;
  logic signed [15:0] kp, ki, kd;
  logic signed [17:0] diff;
  logic signed [34:0] isum;
  logic signed [31:0] integ_clip;
  logic               integ_ovf;
  logic signed [43:0] dsh;
  logic signed [31:0] drive_clip;
  logic               drive_ovf;
  logic               cfg_wr;
  mul_req_t           mreq;
  logic signed [MUL_P_W-1:0] prod_r;

  mpid_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  assign in_ch   = in_tdata[1:0];
  assign in_des  = in_tdata[17:2];
  assign in_meas = in_tdata[33:18];
  assign ch_ok   = int'(in_ch) < CHANNELS;
  assign idx     = ch_r[IDX_W-1:0];
  assign kp      = gain_mem_r[idx][15:0];
  assign ki      = gain_mem_r[idx][31:16];
  assign kd      = gain_mem_r[idx][47:32];

  assign diff = {err_r[16], err_r} - {prev_mem_r[idx][16], prev_mem_r[idx]};

  assign isum = {{3{integ_mem_r[idx][31]}}, integ_mem_r[idx]} + {prod_r[33], prod_r[33:0]};
  assign integ_ovf  = (isum[34:31] != 4'b0000) && (isum[34:31] != 4'b1111);
  assign integ_clip = !integ_ovf ? isum[31:0] :
                      (isum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  assign dsh = acc_r[51:8];
  assign drive_ovf  = (dsh[43:31] != '0) && (dsh[43:31] != '1);
  assign drive_clip = !drive_ovf ? dsh[31:0] :
                      (dsh[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    unique case (state_r)
      S_MI: begin
        mreq.a = {{16{err_r[16]}}, err_r};
        mreq.b = {2'b00, ts_r};
      end
      S_AI: begin
        mreq.a = {{15{diff[17]}}, diff};
        mreq.b = {2'b00, its_r};
      end
      S_KP: begin
        mreq.a = {{16{err_r[16]}}, err_r};
        mreq.b = {{2{kp[15]}}, kp};
      end
      S_KI: begin
        mreq.a = {integ_r[31], integ_r};
        mreq.b = {{2{ki[15]}}, ki};
      end
      S_KDL: begin
        mreq.a = {16'b0, deriv_r[16:0]};
        mreq.b = {{2{kd[15]}}, kd};
      end
      S_KDH: begin
        mreq.a = {{15{deriv_r[34]}}, deriv_r[34:17]};
        mreq.b = {{2{kd[15]}}, kd};
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {16'b0, its_r} : {16'b0, ts_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ts_r        <= TIME_STEP_RST;
      its_r       <= INV_TIME_STEP_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        integ_mem_r[i] <= '0;
        prev_mem_r[i]  <= '0;
        gain_mem_r[i]  <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2]) begin
          its_r <= cfg_pwdata[15:0];
        end else begin
          ts_r <= cfg_pwdata[15:0];
        end
      end
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && ch_ok) begin
            ch_r  <= in_ch;
            err_r <= {in_des[15], in_des} - {in_meas[15], in_meas};
            if (in_tuser == OP_LOAD) begin
              gain_mem_r[in_ch[IDX_W-1:0]] <= in_tdata[81:34];
            end else begin
              state_r <= S_MI;
            end
          end
        end
        S_MI: state_r <= S_AI;
        S_AI: begin
          integ_r <= integ_clip;
          hit_r   <= integ_ovf;
          state_r <= S_KP;
        end
        S_KP: begin
          deriv_r <= prod_r[34:0];
          state_r <= S_KI;
        end
        S_KI: begin
          acc_r   <= {prod_r[MUL_P_W-1], prod_r};
          state_r <= S_KDL;
        end
        S_KDL: begin
          acc_r   <= acc_r + {{17{prod_r[MUL_P_W-1]}}, prod_r[MUL_P_W-1:16]};
          state_r <= S_KDH;
        end
        S_KDH: begin
          acc_r   <= acc_r + {prod_r[MUL_P_W-1], prod_r};
          state_r <= S_FIN;
        end
        S_FIN: begin
          acc_r   <= acc_r + {prod_r[34:0], 17'b0};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r       <= {6'b0, drive_clip, ch_r};
            out_sat_r        <= hit_r || drive_ovf;
            integ_mem_r[idx] <= integ_r;
            prev_mem_r[idx]  <= err_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_STEP && ch_ok) |=> !in_tready)
    else $error("step request did not start the sequence");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_LOAD) |=> in_tready)
    else $error("gain load left the block busy");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result loaded outside the output step");
`endif

endmodule
